/* hw/rtl/hhq_pkg.sv */
`timescale 1ns / 1ps

package hhq_pkg;

    // Grid and fixed-point format
    localparam int GRID_VERTICES = 256;
    localparam int FRACTION_BITS = 16;

    // Grid index and bank addressing: four banks split by column and row parity
    localparam int IDX_W      = $clog2(GRID_VERTICES);
    localparam int HALF_W     = IDX_W - 1;
    localparam int NUM_BANKS  = 4;
    localparam int BANK_AW    = 2 * HALF_W;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // Coordinate mapping
    localparam int COORD_W = 32;
    localparam int INV_W   = 24;
    localparam int PROD_W  = COORD_W + INV_W;
    localparam int CELL_W  = PROD_W - COORD_W;

    // Interpolation datapath
    localparam int HGT_W      = 24;
    localparam int DIFF_W     = HGT_W + 1;
    localparam int WGT_W      = FRACTION_BITS + 1;
    localparam int MUL_W      = WGT_W + 1 + DIFF_W;
    localparam int ACC_W      = HGT_W + FRACTION_BITS + 3;
    localparam int FRAC_ONE   = 1 << FRACTION_BITS;
    localparam int ROUND_HALF = 1 << (FRACTION_BITS - 1);

    // Queues
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 8;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [INV_W-1:0] INV_CELL_RESET = 24'd41779;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 2'd0,
        CFG_ORIGIN_Z      = 2'd1,
        CFG_INV_CELL_SIZE = 2'd2
    } hhq_cfg_idx_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } hhq_func_t;

    // One classified request as it travels from front to back
    typedef struct packed {
        hhq_func_t                 func;
        logic                      outside;
        logic [7:0]                write_col;
        logic [7:0]                write_row;
        logic signed [HGT_W-1:0]   write_height;
        logic [COORD_W-1:0]        local_x;
        logic [COORD_W-1:0]        local_z;
    } hhq_item_t;

endpackage

/* hw/rtl/heightfield_height_query.sv */
`timescale 1ns / 1ps

// Heightfield height query.
// Request channel (push/full): func 0 stores write_height at grid vertex
// (write_col, write_row); func 1 asks for the terrain height at world point
// (query_x, query_z), Q16.16. Writes give no result; each query gives one
// result (height in signed Q16.8, in_range) on the result channel
// (empty/pop), in request order.
// Configuration (cfg_we, cfg_index, cfg_data) sets origin_x, origin_z and
// inv_cell_size; write it only while no request is in flight.
// Throughput: one request per cycle while results are popped. A query
// passes the front register, middle queue, multiply, bank read, corner
// select, weight multiply, and round and push into the result queue before
// its result is visible. Heights are held in four parity banks so all four
// cell corners are read at once.
// Reset clears the queues and pipeline and loads the register defaults;
// heights are undefined until written.
// When pop is held low, the 8-entry result queue fills, the back end stops
// issuing, the 4-entry middle queue fills and full rises; nothing is lost.
module heightfield_height_query
    import hhq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // requests
    input  logic                  push,
    output logic                  full,
    input  logic                  func,
    input  logic [7:0]            write_col,
    input  logic [7:0]            write_row,
    input  logic [HGT_W-1:0]      write_height,
    input  logic [COORD_W-1:0]    query_x,
    input  logic [COORD_W-1:0]    query_z,
    // results
    output logic                  empty,
    input  logic                  pop,
    output logic [HGT_W-1:0]      height,
    output logic                  in_range,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [COORD_W-1:0] origin_x_reg;
    logic [COORD_W-1:0] origin_z_reg;
    logic [INV_W-1:0]   inv_cell_size_reg;

    logic               q_full;
    logic               q_push;
    hhq_item_t          q_item;
    logic               q_empty;
    logic               q_pop;
    hhq_item_t          q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_z_reg      <= '0;
            inv_cell_size_reg <= INV_CELL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                CFG_ORIGIN_Z:      origin_z_reg      <= cfg_data;
                CFG_INV_CELL_SIZE: inv_cell_size_reg <= cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    hhq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .write_col    (write_col),
        .write_row    (write_row),
        .write_height (write_height),
        .query_x      (query_x),
        .query_z      (query_z),
        .origin_x     (origin_x_reg),
        .origin_z     (origin_z_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_item)
    );

    hhq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    hhq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .inv_cell_size (inv_cell_size_reg),
        .empty         (empty),
        .pop           (pop),
        .height        (height),
        .in_range      (in_range)
    );

endmodule

/* hw/rtl/hhq_front.sv */
`timescale 1ns / 1ps

module hhq_front
    import hhq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 push,
    output logic                 full,
    input  logic                 func,
    input  logic [7:0]           write_col,
    input  logic [7:0]           write_row,
    input  logic [HGT_W-1:0]     write_height,
    input  logic [COORD_W-1:0]   query_x,
    input  logic [COORD_W-1:0]   query_z,
    // terrain origin
    input  logic [COORD_W-1:0]   origin_x,
    input  logic [COORD_W-1:0]   origin_z,
    // to the middle queue
    input  logic                 q_full,
    output logic                 q_push,
    output hhq_item_t            q_item
);

    logic            valid_reg;
    logic            valid_next;
    hhq_item_t       item_reg;
    hhq_item_t       item_next;
    logic            accept;
    logic [COORD_W:0] local_x_full;
    logic [COORD_W:0] local_z_full;

    // Handshake: the stage frees up whenever its item moves into the queue
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_item = item_reg;

    // Local coordinates, exact in one extra bit; the sign bit marks "before origin"
    assign local_x_full = {query_x[COORD_W-1], query_x} - {origin_x[COORD_W-1], origin_x};
    assign local_z_full = {query_z[COORD_W-1], query_z} - {origin_z[COORD_W-1], origin_z};

    always_comb
    begin
        item_next.func         = hhq_func_t'(func);
        item_next.outside      = local_x_full[COORD_W] || local_z_full[COORD_W];
        item_next.write_col    = write_col;
        item_next.write_row    = write_row;
        item_next.write_height = write_height;
        item_next.local_x      = local_x_full[COORD_W-1:0];
        item_next.local_z      = local_z_full[COORD_W-1:0];
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* hw/rtl/hhq_queue.sv */
`timescale 1ns / 1ps

module hhq_queue
    import hhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  hhq_item_t   push_item,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output hhq_item_t   head
);

    hhq_item_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/hhq_back.sv */
`timescale 1ns / 1ps

module hhq_back
    import hhq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // from the middle queue
    input  logic                 q_empty,
    input  hhq_item_t            q_head,
    output logic                 q_pop,
    // grid scale
    input  logic [INV_W-1:0]     inv_cell_size,
    // result channel
    output logic                 empty,
    input  logic                 pop,
    output logic [HGT_W-1:0]     height,
    output logic                 in_range
);

    typedef struct packed {
        hhq_func_t                func;
        logic                     outside;
        logic [7:0]               write_col;
        logic [7:0]               write_row;
        logic signed [HGT_W-1:0]  write_height;
        logic [PROD_W-1:0]        prod_x;
        logic [PROD_W-1:0]        prod_z;
    } s2_t;

    typedef struct packed {
        logic                     in_range;
        logic                     cx0;
        logic                     cz0;
        logic [FRACTION_BITS-1:0] fx;
        logic [FRACTION_BITS-1:0] fz;
    } s3_t;

    typedef struct packed {
        logic                     in_range;
        logic signed [HGT_W-1:0]  base;
        logic [WGT_W-1:0]         wa;
        logic signed [DIFF_W-1:0] da;
        logic [WGT_W-1:0]         wb;
        logic signed [DIFF_W-1:0] db;
    } s4_t;

    typedef struct packed {
        logic                     in_range;
        logic signed [HGT_W-1:0]  base;
        logic signed [MUL_W-1:0]  pa;
        logic signed [MUL_W-1:0]  pb;
    } s5_t;

    typedef struct packed {
        logic [HGT_W-1:0] height;
        logic             in_range;
    } res_t;

    // Pipeline registers; stages 3 to 5 carry queries only
    logic                     s1_valid_reg;
    hhq_item_t                s1_reg;
    logic                     s2_valid_reg;
    s2_t                      s2_reg;
    s2_t                      s2_next;
    logic                     s3_valid_reg;
    s3_t                      s3_reg;
    s3_t                      s3_next;
    logic                     s4_valid_reg;
    s4_t                      s4_reg;
    s4_t                      s4_next;
    logic                     s5_valid_reg;
    s5_t                      s5_reg;
    s5_t                      s5_next;

    // Height banks
    logic [HGT_W-1:0]         bank_mem [NUM_BANKS][BANK_DEPTH];
    logic [HGT_W-1:0]         bank_rd_reg [NUM_BANKS];
    logic [BANK_AW-1:0]       bank_addr [NUM_BANKS];
    logic [NUM_BANKS-1:0]     bank_we;

    // Result queue
    res_t                     out_mem_reg [OUT_DEPTH];
    logic [OPTR_W-1:0]        out_wr_ptr_reg;
    logic [OPTR_W-1:0]        out_rd_ptr_reg;
    logic [OCNT_W-1:0]        out_count_reg;
    logic [OCNT_W-1:0]        out_count_next;
    res_t                     res_next;

    logic                     issue;
    logic                     s2_query;
    logic                     s2_write_ok;
    logic [2:0]               inflight;
    logic [CELL_W-1:0]        cell_x;
    logic [CELL_W-1:0]        cell_z;
    logic [IDX_W-1:0]         cx_idx;
    logic [IDX_W-1:0]         cz_idx;
    logic [IDX_W-1:0]         wcol_idx;
    logic [IDX_W-1:0]         wrow_idx;
    logic signed [HGT_W-1:0]  h00;
    logic signed [HGT_W-1:0]  h10;
    logic signed [HGT_W-1:0]  h01;
    logic signed [HGT_W-1:0]  h11;
    logic                     lower_tri;
    logic signed [ACC_W-1:0]  acc;
    logic                     out_pop;

    // Credit check: an item issues only if every query in flight has a slot waiting
    always_comb
    begin
        inflight = 3'(s1_valid_reg && (s1_reg.func == FUNC_QUERY))
                 + 3'(s2_valid_reg && (s2_reg.func == FUNC_QUERY))
                 + 3'(s3_valid_reg) + 3'(s4_valid_reg) + 3'(s5_valid_reg);
    end

    assign issue = !q_empty
                && ((OCNT_W + 1)'(out_count_reg) + (OCNT_W + 1)'(inflight))
                   < (OCNT_W + 1)'(OUT_DEPTH);
    assign q_pop = issue;

    // Stage 1 -> 2: scale local coordinates by the reciprocal cell size
    always_comb
    begin
        s2_next.func         = s1_reg.func;
        s2_next.outside      = s1_reg.outside;
        s2_next.write_col    = s1_reg.write_col;
        s2_next.write_row    = s1_reg.write_row;
        s2_next.write_height = s1_reg.write_height;
        s2_next.prod_x       = PROD_W'(s1_reg.local_x) * PROD_W'(inv_cell_size);
        s2_next.prod_z       = PROD_W'(s1_reg.local_z) * PROD_W'(inv_cell_size);
    end

    // Stage 2: cell, fractions, range check and bank addresses
    assign s2_query    = s2_valid_reg && (s2_reg.func == FUNC_QUERY);
    assign s2_write_ok = (32'(s2_reg.write_col) < GRID_VERTICES)
                      && (32'(s2_reg.write_row) < GRID_VERTICES);
    assign cell_x      = s2_reg.prod_x[PROD_W-1:COORD_W];
    assign cell_z      = s2_reg.prod_z[PROD_W-1:COORD_W];
    assign cx_idx      = IDX_W'(cell_x);
    assign cz_idx      = IDX_W'(cell_z);
    assign wcol_idx    = IDX_W'(s2_reg.write_col);
    assign wrow_idx    = IDX_W'(s2_reg.write_row);

    always_comb
    begin
        s3_next.in_range = !s2_reg.outside
                        && (cell_x < CELL_W'(GRID_VERTICES - 1))
                        && (cell_z < CELL_W'(GRID_VERTICES - 1));
        s3_next.cx0      = cell_x[0];
        s3_next.cz0      = cell_z[0];
        s3_next.fx       = s2_reg.prod_x[COORD_W-1 -: FRACTION_BITS];
        s3_next.fz       = s2_reg.prod_z[COORD_W-1 -: FRACTION_BITS];
    end

    // Each corner of a cell lands in a different parity bank
    always_comb
    begin
        logic             bx;
        logic             bz;
        logic [IDX_W-1:0] col_sel;
        logic [IDX_W-1:0] row_sel;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bx = b[0];
            bz = b[1];
            if (s2_reg.func == FUNC_WRITE)
            begin
                col_sel = wcol_idx;
                row_sel = wrow_idx;
            end
            else
            begin
                col_sel = cx_idx + IDX_W'(bx != cx_idx[0]);
                row_sel = cz_idx + IDX_W'(bz != cz_idx[0]);
            end
            bank_addr[b] = {row_sel[IDX_W-1:1], col_sel[IDX_W-1:1]};
            bank_we[b]   = s2_valid_reg && (s2_reg.func == FUNC_WRITE) && s2_write_ok
                        && (wcol_idx[0] == bx) && (wrow_idx[0] == bz);
        end
    end

    for (genvar gb = 0; gb < NUM_BANKS; gb++)
    begin : g_bank
        always_ff @(posedge clk)
        begin
            if (bank_we[gb])
            begin
                bank_mem[gb][bank_addr[gb]] <= s2_reg.write_height;
            end
            bank_rd_reg[gb] <= bank_mem[gb][bank_addr[gb]];
        end
    end

    // Stage 3: unscramble banks into corners, pick triangle, form differences
    always_comb
    begin
        case ({s3_reg.cz0, s3_reg.cx0})
            2'b00:
            begin
                h00 = bank_rd_reg[0];
                h10 = bank_rd_reg[1];
                h01 = bank_rd_reg[2];
                h11 = bank_rd_reg[3];
            end
            2'b01:
            begin
                h00 = bank_rd_reg[1];
                h10 = bank_rd_reg[0];
                h01 = bank_rd_reg[3];
                h11 = bank_rd_reg[2];
            end
            2'b10:
            begin
                h00 = bank_rd_reg[2];
                h10 = bank_rd_reg[3];
                h01 = bank_rd_reg[0];
                h11 = bank_rd_reg[1];
            end
            default:
            begin
                h00 = bank_rd_reg[3];
                h10 = bank_rd_reg[2];
                h01 = bank_rd_reg[1];
                h11 = bank_rd_reg[0];
            end
        endcase
    end

    assign lower_tri = (WGT_W'(s3_reg.fx) + WGT_W'(s3_reg.fz)) <= WGT_W'(FRAC_ONE);

    always_comb
    begin
        s4_next.in_range = s3_reg.in_range;
        s4_next.wa       = WGT_W'(s3_reg.fx);
        if (lower_tri)
        begin
            s4_next.base = h00;
            s4_next.da   = DIFF_W'(h10) - DIFF_W'(h00);
            s4_next.wb   = WGT_W'(s3_reg.fz);
            s4_next.db   = DIFF_W'(h01) - DIFF_W'(h00);
        end
        else
        begin
            s4_next.base = h01;
            s4_next.da   = DIFF_W'(h11) - DIFF_W'(h01);
            s4_next.wb   = WGT_W'(FRAC_ONE) - WGT_W'(s3_reg.fz);
            s4_next.db   = DIFF_W'(h10) - DIFF_W'(h11);
        end
    end

    // Stage 4: weight products
    always_comb
    begin
        s5_next.in_range = s4_reg.in_range;
        s5_next.base     = s4_reg.base;
        s5_next.pa       = MUL_W'($signed({1'b0, s4_reg.wa})) * MUL_W'(s4_reg.da);
        s5_next.pb       = MUL_W'($signed({1'b0, s4_reg.wb})) * MUL_W'(s4_reg.db);
    end

    // Stage 5: sum, round to nearest (ties up), zero when outside
    always_comb
    begin
        acc = (ACC_W'(s5_reg.base) <<< FRACTION_BITS) + ACC_W'(s5_reg.pa)
            + ACC_W'(s5_reg.pb) + ACC_W'(ROUND_HALF);
        res_next.in_range = s5_reg.in_range;
        res_next.height   = s5_reg.in_range ? acc[FRACTION_BITS + HGT_W - 1:FRACTION_BITS]
                                            : '0;
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_query;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg <= q_head;
        end
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
        s5_reg <= s5_next;
    end

    // Result queue
    assign empty    = (out_count_reg == '0);
    assign out_pop  = pop && !empty;
    assign height   = out_mem_reg[out_rd_ptr_reg].height;
    assign in_range = out_mem_reg[out_rd_ptr_reg].in_range;

    always_comb
    begin
        out_count_next = out_count_reg;
        if (s5_valid_reg && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (out_pop && !s5_valid_reg)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            out_count_reg <= out_count_next;
            if (s5_valid_reg)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_valid_reg)
        begin
            out_mem_reg[out_wr_ptr_reg] <= res_next;
        end
    end

`ifndef SYNTHESIS
    // Credits never overcommit the result queue
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((OCNT_W + 1)'(out_count_reg) + (OCNT_W + 1)'(inflight))
            <= (OCNT_W + 1)'(OUT_DEPTH))
        else $error("result credits overcommitted");

    // A finishing query always finds a free slot
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (out_count_reg < OCNT_W'(OUT_DEPTH)))
        else $error("result queue overflow");

    // Height writes leave the pipeline after the bank stage
    a_write_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_reg.func == FUNC_WRITE)) |=> !s3_valid_reg)
        else $error("write request reached interpolation stage");
`endif

endmodule
